// ===== hw/rtl/dfdl_pkg.sv =====
// Package for the decimating FIR, de-emphasis and limiter block.
// Holds shared widths, reset values, register and action codes, and divider types.
// No dependencies.
package dfdl_pkg;

  localparam int DFDL_MAX_TAPS = 64;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int LEVEL_W  = 24;
  localparam int CFG_W    = 16;

  localparam logic [6:0]  DECIM_RESET = 7'd1;
  localparam logic [6:0]  TAPS_RESET  = 7'd64;
  localparam logic [15:0] ALPHA_RESET = 16'd19275;
  localparam logic [15:0] DECAY_RESET = 16'd65503;
  localparam logic [23:0] PEAK_RESET  = 24'd8389;

  // 0.9 in Q0.15.
  localparam int GAIN_Q15 = 29491;

  // Rounding divider: numerator 2*|num| + den, denominator 2*den.
  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 26;
  localparam int DIV_Q_W   = 17;

  typedef enum logic [1:0] {
    REG_DECIM = 2'd0,
    REG_TAPS  = 2'd1,
    REG_ALPHA = 2'd2,
    REG_DECAY = 2'd3
  } dfdl_reg_t;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } dfdl_div_stat_t;

endpackage

// ===== hw/rtl/decimating_fir_deemphasis_limiter_unit.sv =====
// Decimating FIR, de-emphasis and peak limiter around one shared multiplier.
// Depends on dfdl_pkg and dfdl_div.
// Coefficient writes and samples that produce no output are taken without leaving
// idle; an output sample passes through the MAC, post-filter, divider and output steps,
// and waits in S_OUT while the previous result waits on out_ready.
// Reset is synchronous: history reads as zero, registers take their defaults.
module decimating_fir_deemphasis_limiter_unit import dfdl_pkg::*; #(
  parameter int MAX_TAPS = DFDL_MAX_TAPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [5:0]                 coef_index,
  input  logic signed [COEF_W-1:0]   coef_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] audio,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int NW    = AW + 1;
  localparam int PW    = 43;
  localparam int ACC_W = SAMPLE_W + COEF_W + AW;
  localparam int X_MAX = 8388607;
  localparam int X_MIN = -8388608;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_ROUND, S_DMUL, S_DUPD, S_PMUL, S_PUPD, S_GMUL,
    S_DSET, S_DWAIT, S_OUT
  } state_t;

  state_t state;

  logic [6:0]  r_decim;
  logic [6:0]  r_taps;
  logic [15:0] r_alpha;
  logic [15:0] r_decay;

  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        hist_valid;

  logic [AW-1:0]              write_pos;
  logic [5:0]                 decim_phase;
  logic signed [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]         peak;

  logic [NW-1:0]              kcnt;
  logic [AW-1:0]              rd_idx;
  logic                       rd_v;
  logic                       mul_v;
  logic signed [COEF_W-1:0]   coef_rd;
  logic signed [SAMPLE_W-1:0] hist_rd;
  logic                       hist_ok;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PW-1:0]       p;
  logic signed [LEVEL_W-1:0]  x_r;
  logic [LEVEL_W-1:0]         ay_r;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] res_r;

  logic [NW-1:0]              n_eff;
  logic [6:0]                 m_eff;
  logic [AW-1:0]              wp;
  logic [NW-1:0]              wp_inc;
  logic [AW-1:0]              wp_new;
  logic [AW-1:0]              first_idx;
  logic [AW-1:0]              next_idx;
  logic                       issue;
  logic                       hist_take;
  logic                       coef_take;
  logic                       phase_more;

  logic signed [24:0]         ma;
  logic signed [17:0]         mb;
  logic signed [24:0]         dval;
  logic signed [ACC_W:0]      rsum;
  logic signed [ACC_W:0]      rsh;
  logic signed [LEVEL_W-1:0]  x_sat;
  logic signed [PW-1:0]       pr;
  logic signed [PW-1:0]       pr_sh;
  logic signed [27:0]         y_wide;
  logic signed [LEVEL_W-1:0]  y_sat;
  logic signed [24:0]         y25;
  logic signed [24:0]         ay25;
  logic [LEVEL_W-1:0]         peak_dec;
  logic [PW-1:0]              mag;
  logic [24:0]                den;
  logic [DIV_NUM_W-1:0]       div_num;
  logic [DIV_DEN_W-1:0]       div_den;
  dfdl_div_stat_t             div_stat;
  logic [DIV_Q_W-1:0]         quot;
  logic signed [SAMPLE_W-1:0] result;

  assign in_ready  = (state == S_IDLE);
  assign hist_take = in_valid && in_ready && (action == ACT_SAMPLE);
  assign coef_take = in_valid && in_ready && (action == ACT_COEF);

  // Clamp the register values to the ranges the datapath supports.
  always_comb begin
    int t;
    t = int'(r_taps);
    if (t == 0) begin
      t = 1;
    end else if (t > MAX_TAPS) begin
      t = MAX_TAPS;
    end
    n_eff = NW'(t);
    if (r_decim == 7'd0) begin
      m_eff = 7'd1;
    end else if (r_decim > 7'd64) begin
      m_eff = 7'd64;
    end else begin
      m_eff = r_decim;
    end
  end

  // Ring pointer: restart at entry 0 if the ring has shrunk under it.
  always_comb begin
    wp        = ({1'b0, write_pos} >= n_eff) ? '0 : write_pos;
    wp_inc    = {1'b0, wp} + 1'b1;
    wp_new    = (wp_inc >= n_eff) ? '0 : wp_inc[AW-1:0];
    first_idx = (wp_new == '0) ? n_eff[AW-1:0] - 1'b1 : wp_new - 1'b1;
    next_idx  = (rd_idx == '0) ? n_eff[AW-1:0] - 1'b1 : rd_idx - 1'b1;
  end

  assign phase_more = ({1'b0, decim_phase} + 7'd1) < m_eff;
  assign issue      = (state == S_MAC) && (kcnt < n_eff);

  // Operand selection for the shared multiplier.
  assign dval = {x_r[LEVEL_W-1], x_r} - {level[LEVEL_W-1], level};

  always_comb begin
    case (state)
      S_DMUL: begin
        ma = dval;
        mb = {2'b00, r_alpha};
      end
      S_PMUL: begin
        ma = {1'b0, peak};
        mb = {2'b00, r_decay};
      end
      S_GMUL: begin
        ma = {level[LEVEL_W-1], level};
        mb = 18'(GAIN_Q15);
      end
      default: begin
        ma = hist_ok ? 25'(hist_rd) : '0;
        mb = coef_rd;
      end
    endcase
  end

  // Round the FIR sum to Q1.23 and saturate.
  always_comb begin
    rsum = {acc[ACC_W-1], acc} + (ACC_W + 1)'(256);
    rsh  = rsum >>> 9;
    if (rsh > (ACC_W + 1)'(X_MAX)) begin
      x_sat = LEVEL_W'(X_MAX);
    end else if (rsh < (ACC_W + 1)'(X_MIN)) begin
      x_sat = LEVEL_W'(X_MIN);
    end else begin
      x_sat = rsh[LEVEL_W-1:0];
    end
  end

  // De-emphasis update and the decayed peak.
  always_comb begin
    pr     = p + PW'(32768);
    pr_sh  = pr >>> 16;
    y_wide = {{4{level[LEVEL_W-1]}}, level} + pr_sh[27:0];
    if (y_wide > 28'(X_MAX)) begin
      y_sat = LEVEL_W'(X_MAX);
    end else if (y_wide < 28'(X_MIN)) begin
      y_sat = LEVEL_W'(X_MIN);
    end else begin
      y_sat = y_wide[LEVEL_W-1:0];
    end
    y25      = {y_sat[LEVEL_W-1], y_sat};
    ay25     = y25[24] ? -y25 : y25;
    peak_dec = pr[39:16];
  end

  // Gain: round(|y*0.9| / (peak + 1)) through the rounding divider.
  always_comb begin
    mag     = p[PW-1] ? PW'(-p) : PW'(p);
    den     = {1'b0, peak} + 25'd1;
    div_num = {1'b0, mag[38:0], 1'b0} + DIV_NUM_W'(den);
    div_den = {den, 1'b0};
    if (quot[DIV_Q_W-1] || quot[DIV_Q_W-2]) begin
      result = neg_r ? 16'sh8000 : 16'sh7FFF;
    end else if (neg_r) begin
      result = -$signed({1'b0, quot[14:0]});
    end else begin
      result = $signed({1'b0, quot[14:0]});
    end
  end

  dfdl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSET),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (quot)
  );

  // Coefficient table and sample history, with registered reads.
  always_ff @(posedge clk) begin
    if (coef_take && (int'(coef_index) < MAX_TAPS)) begin
      coef_mem[AW'(coef_index)] <= coef_value;
    end
    if (hist_take) begin
      hist_mem[wp] <= sample;
    end
    coef_rd <= coef_mem[issue ? kcnt[AW-1:0] : '0];
    hist_rd <= hist_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      r_decim     <= DECIM_RESET;
      r_taps      <= TAPS_RESET;
      r_alpha     <= ALPHA_RESET;
      r_decay     <= DECAY_RESET;
      hist_valid  <= '0;
      write_pos   <= '0;
      decim_phase <= '0;
      level       <= '0;
      peak        <= PEAK_RESET;
      kcnt        <= '0;
      rd_v        <= 1'b0;
      mul_v       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (dfdl_reg_t'(cfg_index))
          REG_DECIM: r_decim <= cfg_data[6:0];
          REG_TAPS:  r_taps  <= cfg_data[6:0];
          REG_ALPHA: r_alpha <= cfg_data;
          REG_DECAY: r_decay <= cfg_data;
        endcase
      end

      // In S_OUT the output register is refilled directly.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      hist_ok <= hist_valid[rd_idx];
      rd_v    <= issue;
      mul_v   <= rd_v;

      unique case (state)
        S_IDLE: begin
          if (hist_take) begin
            hist_valid[wp] <= 1'b1;
            write_pos      <= wp_new;
            if (phase_more) begin
              decim_phase <= decim_phase + 6'd1;
            end else begin
              decim_phase <= '0;
              acc         <= '0;
              kcnt        <= '0;
              rd_idx      <= first_idx;
              state       <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (issue) begin
            kcnt   <= kcnt + 1'b1;
            rd_idx <= next_idx;
          end
          if (mul_v) begin
            acc <= acc + ACC_W'(p);
          end
          // The last product is added on the edge that leaves this state.
          if (!issue && !rd_v) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          x_r   <= x_sat;
          state <= S_DMUL;
        end
        S_DMUL: begin
          state <= S_DUPD;
        end
        S_DUPD: begin
          level <= y_sat;
          ay_r  <= ay25[LEVEL_W-1:0];
          state <= S_PMUL;
        end
        S_PMUL: begin
          state <= S_PUPD;
        end
        S_PUPD: begin
          peak  <= (ay_r > peak) ? ay_r : peak_dec;
          state <= S_GMUL;
        end
        S_GMUL: begin
          state <= S_DSET;
        end
        S_DSET: begin
          neg_r <= p[PW-1];
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_stat.done && !div_stat.busy) begin
            res_r <= result;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            audio     <= res_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/dfdl_div.sv =====
// Restoring divider, one quotient bit per cycle, for the limiter gain.
// Depends on dfdl_pkg for widths and the status struct.
module dfdl_div import dfdl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output dfdl_div_stat_t       stat,
  output logic [DIV_Q_W-1:0]   quot
);

  localparam int RW = DIV_DEN_W + DIV_Q_W - 1;
  localparam int CW = $clog2(DIV_Q_W);

  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic          fits;

  assign fits = (rem >= dsh);
  assign stat = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(DIV_Q_W - 1));
      if (start) begin
        rem  <= RW'(num);
        dsh  <= {den, (DIV_Q_W - 1)'(0)};
        quot <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quot <= {quot[DIV_Q_W-2:0], fits};
        dsh  <= dsh >> 1;
        if (cnt == CW'(DIV_Q_W - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/dfdl_checker.sv =====
// Port-level checks for the decimating FIR, de-emphasis and limiter block.
// Depends on dfdl_pkg; bound to the top level at the end of this file.
module dfdl_checker import dfdl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] audio
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(audio))
    else $error("output transaction changed before it was taken");

  // A coefficient write never makes the block busy.
  a_coef_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_COEF) |=> in_ready)
    else $error("block busy after a coefficient write");

  // A new result is only presented at the end of a busy period.
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // Reset leaves the block ready with no pending result.
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind decimating_fir_deemphasis_limiter_unit dfdl_checker u_dfdl_checker (.*);
